[rtl/ppurp_pkg.sv]
// ----------------------------------------------------------------------------
// ppurp_pkg
// Shared types and constants for the video unit register port.
// ----------------------------------------------------------------------------
`default_nettype none

package ppurp_pkg;

  // bus request kind
  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_LOAD  = 2'd2
  } cmd_e;

  // cpu-visible register numbers
  typedef enum logic [2:0] {
    REG_CTRL     = 3'd0,
    REG_MASK     = 3'd1,
    REG_STATUS   = 3'd2,
    REG_OAM_ADDR = 3'd3,
    REG_OAM_DATA = 3'd4,
    REG_SCROLL   = 3'd5,
    REG_ADDR     = 3'd6,
    REG_DATA     = 3'd7
  } reg_e;

  // where the response byte comes from
  typedef enum logic [2:0] {
    RSP_IMM    = 3'd0,
    RSP_SPRITE = 3'd1,
    RSP_PAT    = 3'd2,
    RSP_NTAB   = 3'd3,
    RSP_PAL    = 3'd4
  } rsp_sel_e;

  localparam int unsigned VADDR_W   = 14;
  localparam int unsigned PAT_AW    = 13;
  localparam int unsigned SPRITE_AW = 8;
  localparam int unsigned PAL_AW    = 5;

  localparam logic [VADDR_W-1:0] VA_NTAB_BASE = 14'h2000;
  localparam logic [VADDR_W-1:0] VA_NTAB_END  = 14'h3000;
  localparam logic [VADDR_W-1:0] VA_PAL_BASE  = 14'h3F00;
  localparam logic [VADDR_W-1:0] VA_MIRROR    = 14'h1000;
  localparam logic [VADDR_W-1:0] STEP_ROW     = 14'd32;
  localparam logic [VADDR_W-1:0] STEP_BYTE    = 14'd1;
  localparam logic [7:0]         NTAB_FILL    = 8'hFF;

  // controller to datapath
  typedef struct packed {
    logic clear_we;
    logic exec;
    logic load_out;
  } ppurp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic out_busy;
  } ppurp_sts_t;

endpackage

`default_nettype wire

[rtl/ppu_register_port_vram.sv]
// ----------------------------------------------------------------------------
// ppu_register_port_vram
// CPU register port of a tile video unit with its video memories.
// ----------------------------------------------------------------------------
//
//  channel   direction  payload                                    moves
//  s_axis    in         tuser: command, reg_select                 one request
//                       tdata: data, pattern_addr
//  m_axis    out        tdata: read_data                           one byte
//  cfg       in         cfg_wdata_i: nametable mirroring           one bit
//
//  on each request the accepting edge does all register and memory writes
//  and launches the registered memory reads; the response state then picks
//  the response byte into the output register once that register is free
//  after reset a clearing pass fills the nametable with 0xff and zeroes
//  sprite and palette memory; no request is taken then (mirroring writes
//  are taken as always)
//  a held response does not block acceptance of the next request; only a
//  second response waiting on a stalled output holds the port
//  pattern memory has no reset and is meant to be loaded before it is read
// ----------------------------------------------------------------------------
`default_nettype none

module ppu_register_port_vram #(
  parameter int unsigned NAMETABLE_BYTES = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // mirroring register: 0 horizontal, 1 vertical
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,
  // request stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // [7:0] data, [20:8] pattern_addr
  input  wire logic [4:0]  s_axis_tuser,  // [1:0] command, [4:2] reg_select
  // response stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata   // [7:0] read_data
);

  ppurp_pkg::ppurp_cmd_t cmd;
  ppurp_pkg::ppurp_sts_t sts;

  // sequencer: clearing pass, accept, hand-off
  ppurp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // registers, address mirroring and memories
  ppurp_dpath #(
    .NAMETABLE_BYTES (NAMETABLE_BYTES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_cmd_i    (s_axis_tuser[1:0]),
    .in_reg_i    (s_axis_tuser[4:2]),
    .in_data_i   (s_axis_tdata[7:0]),
    .in_paddr_i  (s_axis_tdata[20:8]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

[rtl/ppurp_ctrl.sv]
// ----------------------------------------------------------------------------
// ppurp_ctrl
// Sequencer: memory clearing pass, request acceptance and response hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module ppurp_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  req_valid_i,
  output logic                       req_ready_o,
  input  wire ppurp_pkg::ppurp_sts_t sts_i,
  output ppurp_pkg::ppurp_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_RESP  = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d        = state_q;
    cmd_o.clear_we = 1'b0;
    cmd_o.exec     = 1'b0;
    cmd_o.load_out = 1'b0;
    req_ready_o    = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_we = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.exec = 1'b1;
          state_d    = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!sts_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  a_exec_then_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> state_q == ST_RESP)
    else $error("accepted request not followed by response state");

  a_no_exec_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !cmd_o.exec && !cmd_o.load_out)
    else $error("request handled during clearing pass");

  a_load_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> !sts_i.out_busy)
    else $error("response loaded over a pending one");

  a_clear_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR && sts_i.clear_last) |=> state_q == ST_IDLE)
    else $error("clearing pass did not finish");

endmodule

`default_nettype wire

[rtl/ppurp_dpath.sv]
// ----------------------------------------------------------------------------
// ppurp_dpath
// Register file, address mirroring, video memories and response register.
// ----------------------------------------------------------------------------
`default_nettype none

module ppurp_dpath #(
  parameter int unsigned NAMETABLE_BYTES = 4096
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_wdata_i,
  input  wire logic [1:0]            in_cmd_i,
  input  wire logic [2:0]            in_reg_i,
  input  wire logic [7:0]            in_data_i,
  input  wire logic [12:0]           in_paddr_i,
  input  wire ppurp_pkg::ppurp_cmd_t cmd_i,
  output ppurp_pkg::ppurp_sts_t      sts_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [7:0]                 out_data_o
);

  localparam int unsigned NT_AW = $clog2(NAMETABLE_BYTES);
  localparam int unsigned VW    = ppurp_pkg::VADDR_W;
  localparam logic [12:0] NT_SIZE = 13'(NAMETABLE_BYTES);
  localparam logic [NT_AW-1:0] NT_LAST = NT_AW'(NAMETABLE_BYTES - 1);

  // architectural registers
  logic          mirror_q;
  logic          inc_row_q;
  logic [7:0]    sprite_addr_q;
  logic [VW-1:0] scroll_q, scroll_d;
  logic [VW-1:0] vptr_q, vptr_d;
  logic          toggle_q, toggle_d;
  logic [3:0]    status_q;
  logic [NT_AW-1:0] clr_cnt_q;

  // memories
  logic [7:0] pat_mem    [2**ppurp_pkg::PAT_AW];
  logic [7:0] ntab_mem   [NAMETABLE_BYTES];
  logic [7:0] pal_mem    [2**ppurp_pkg::PAL_AW];
  logic [7:0] sprite_mem [2**ppurp_pkg::SPRITE_AW];
  logic [7:0] pat_rd_q, ntab_rd_q, pal_rd_q, sprite_rd_q;

  ppurp_pkg::rsp_sel_e rsp_sel_q, rsp_sel_d;
  logic [7:0] rsp_imm_q, rsp_imm_d;
  logic       out_valid_q;
  logic [7:0] out_data_q, rsp_byte;

  logic is_rd, is_wr, is_ld;
  ppurp_pkg::reg_e rsel;

  assign is_rd = cmd_i.exec && (in_cmd_i == ppurp_pkg::CMD_READ);
  assign is_wr = cmd_i.exec && (in_cmd_i == ppurp_pkg::CMD_WRITE);
  assign is_ld = cmd_i.exec && (in_cmd_i == ppurp_pkg::CMD_LOAD);
  assign rsel  = ppurp_pkg::reg_e'(in_reg_i);

  // address mirroring of the data pointer
  logic [VW-1:0] va1;
  logic          va_is_pat, va_is_pal;
  logic [11:0]   nt_off;
  logic [12:0]   nt_wrap;
  logic [NT_AW-1:0] nt_idx;

  always_comb begin
    va1 = vptr_q;
    if (vptr_q >= ppurp_pkg::VA_NTAB_END && vptr_q < ppurp_pkg::VA_PAL_BASE) begin
      va1 = vptr_q - ppurp_pkg::VA_MIRROR;
    end
    va_is_pat = va1 < ppurp_pkg::VA_NTAB_BASE;
    va_is_pal = va1 >= ppurp_pkg::VA_PAL_BASE;
    // horizontal folds the 0x400 bit, vertical the 0x800 bit
    if (mirror_q) begin
      nt_off = {1'b0, va1[10], va1[9:0]};
    end else begin
      nt_off = {va1[11], 1'b0, va1[9:0]};
    end
    nt_wrap = {1'b0, nt_off};
    if (nt_wrap >= NT_SIZE) begin
      nt_wrap = nt_wrap - NT_SIZE;
    end
    nt_idx = nt_wrap[NT_AW-1:0];
  end

  logic data_acc;
  logic [VW-1:0] vptr_next;

  assign data_acc  = (is_rd || is_wr) && (rsel == ppurp_pkg::REG_DATA);
  assign vptr_next = vptr_q + (inc_row_q ? ppurp_pkg::STEP_ROW : ppurp_pkg::STEP_BYTE);

  // register writes and latches
  always_comb begin
    scroll_d  = scroll_q;
    vptr_d    = data_acc ? vptr_next : vptr_q;
    toggle_d  = toggle_q;
    rsp_sel_d = ppurp_pkg::RSP_IMM;
    rsp_imm_d = 8'h00;
    if (is_wr) begin
      unique case (rsel)
        ppurp_pkg::REG_CTRL: scroll_d[11:10] = in_data_i[1:0];
        ppurp_pkg::REG_SCROLL: begin
          if (!toggle_q) begin
            scroll_d[4:0] = in_data_i[7:3];
          end else begin
            // fine y top bit never reaches the pointer
            scroll_d[13:12] = in_data_i[1:0];
            scroll_d[9:5]   = in_data_i[7:3];
          end
          toggle_d = !toggle_q;
        end
        ppurp_pkg::REG_ADDR: begin
          if (!toggle_q) begin
            scroll_d[13:8] = in_data_i[5:0];
          end else begin
            scroll_d[7:0] = in_data_i;
            vptr_d        = {scroll_q[13:8], in_data_i};
          end
          toggle_d = !toggle_q;
        end
        default: ;
      endcase
    end
    if (is_rd) begin
      unique case (rsel)
        ppurp_pkg::REG_STATUS: begin
          rsp_imm_d = {4'h0, status_q};
          toggle_d  = 1'b0;
        end
        ppurp_pkg::REG_OAM_DATA: rsp_sel_d = ppurp_pkg::RSP_SPRITE;
        ppurp_pkg::REG_DATA: begin
          if (va_is_pat) begin
            rsp_sel_d = ppurp_pkg::RSP_PAT;
          end else if (va_is_pal) begin
            rsp_sel_d = ppurp_pkg::RSP_PAL;
          end else begin
            rsp_sel_d = ppurp_pkg::RSP_NTAB;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mirror_q      <= 1'b0;
      inc_row_q     <= 1'b0;
      sprite_addr_q <= '0;
      scroll_q      <= '0;
      vptr_q        <= '0;
      toggle_q      <= 1'b0;
      status_q      <= '0;
      clr_cnt_q     <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mirror_q <= cfg_wdata_i;
      end
      if (is_wr) begin
        status_q <= in_data_i[3:0];
        if (rsel == ppurp_pkg::REG_CTRL) begin
          inc_row_q <= in_data_i[2];
        end
        if (rsel == ppurp_pkg::REG_OAM_ADDR) begin
          sprite_addr_q <= in_data_i;
        end
      end
      scroll_q <= scroll_d;
      vptr_q   <= vptr_d;
      toggle_q <= toggle_d;
      if (cmd_i.clear_we) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      rsp_sel_q <= rsp_sel_d;
      rsp_imm_q <= rsp_imm_d;
    end
    if (cmd_i.load_out) begin
      out_data_q <= rsp_byte;
    end
  end

  // pattern memory: loaded directly, read-only through the data port
  always_ff @(posedge clk_i) begin
    if (is_ld) begin
      pat_mem[in_paddr_i] <= in_data_i;
    end
    if (is_rd) begin
      pat_rd_q <= pat_mem[va1[ppurp_pkg::PAT_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_we) begin
      ntab_mem[clr_cnt_q] <= ppurp_pkg::NTAB_FILL;
    end else if (data_acc && is_wr && !va_is_pat && !va_is_pal) begin
      ntab_mem[nt_idx] <= in_data_i;
    end
    if (is_rd) begin
      ntab_rd_q <= ntab_mem[nt_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_we && clr_cnt_q[NT_AW-1:ppurp_pkg::PAL_AW] == '0) begin
      pal_mem[clr_cnt_q[ppurp_pkg::PAL_AW-1:0]] <= 8'h00;
    end else if (data_acc && is_wr && va_is_pal) begin
      pal_mem[va1[ppurp_pkg::PAL_AW-1:0]] <= in_data_i;
    end
    if (is_rd) begin
      pal_rd_q <= pal_mem[va1[ppurp_pkg::PAL_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_we && clr_cnt_q[NT_AW-1:ppurp_pkg::SPRITE_AW] == '0) begin
      sprite_mem[clr_cnt_q[ppurp_pkg::SPRITE_AW-1:0]] <= 8'h00;
    end else if (is_wr && rsel == ppurp_pkg::REG_OAM_DATA) begin
      sprite_mem[sprite_addr_q] <= in_data_i;
    end
    if (is_rd) begin
      sprite_rd_q <= sprite_mem[sprite_addr_q];
    end
  end

  always_comb begin
    case (rsp_sel_q)
      ppurp_pkg::RSP_SPRITE: rsp_byte = sprite_rd_q;
      ppurp_pkg::RSP_PAT:    rsp_byte = pat_rd_q;
      ppurp_pkg::RSP_NTAB:   rsp_byte = ntab_rd_q;
      ppurp_pkg::RSP_PAL:    rsp_byte = pal_rd_q;
      default:               rsp_byte = rsp_imm_q;
    endcase
  end

  assign sts_o.clear_last = clr_cnt_q == NT_LAST;
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;
  assign out_valid_o      = out_valid_q;
  assign out_data_o       = out_data_q;

endmodule

`default_nettype wire
